FILE: sv/lpk_pkg.sv
package lpk_pkg;

  localparam int unsigned TableSlots = 1024;
  localparam int unsigned SlotW      = $clog2(TableSlots);
  localparam int unsigned MaxEntries = (3 * TableSlots - 1) / 4;
  localparam int unsigned EntryW     = $clog2(MaxEntries + 1);

  typedef enum logic {
    OP_FIND   = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT_CHK,
    S_KEY_CHK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] mid;
    logic [31:0] lo;
  } key_t;

  typedef struct packed {
    logic              rd_en;
    logic [SlotW-1:0]  rd_addr;
    logic              wr_en;
    logic [SlotW-1:0]  wr_addr;
    logic [EntryW-1:0] wr_data;
  } slot_req_t;

  typedef struct packed {
    logic              rd_en;
    logic [EntryW-1:0] rd_addr;
    logic              wr_en;
    logic [EntryW-1:0] wr_addr;
    key_t              wr_key;
  } key_req_t;

endpackage

FILE: sv/lpk_if.sv
interface lpk_req_if;
  logic              valid;
  logic              ready;
  lpk_pkg::op_e      opcode;
  logic [63:0]       key_hi;
  logic [63:0]       key_mid;
  logic [31:0]       key_lo;

  modport source (output valid, opcode, key_hi, key_mid, key_lo, input ready);
  modport sink   (input valid, opcode, key_hi, key_mid, key_lo, output ready);
endinterface

interface lpk_rsp_if;
  logic                          valid;
  logic                          ready;
  lpk_pkg::status_e              status;
  logic [lpk_pkg::EntryW-1:0]    entry_index;

  modport source (output valid, status, entry_index, input ready);
  modport sink   (input valid, status, entry_index, output ready);
endinterface

FILE: sv/lpk_slot_mem.sv
module lpk_slot_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lpk_pkg::slot_req_t              req_i,
  output logic [lpk_pkg::EntryW-1:0]      rdata_o,
  output logic                            ready_o
);
  import lpk_pkg::*;

  logic [EntryW-1:0] mem [TableSlots];
  logic [EntryW-1:0] rdata_q;
  logic [SlotW-1:0]  clr_addr_q, clr_addr_d;
  logic              clearing_q, clearing_d;
  logic              we;
  logic [SlotW-1:0]  waddr;
  logic [EntryW-1:0] wdata;

  // sweep writes zero into every slot after reset
  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + SlotW'(1);
      if (clr_addr_q == {SlotW{1'b1}}) clearing_d = 1'b0;
    end
  end

  always_comb begin
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else begin
      we    = req_i.wr_en;
      waddr = req_i.wr_addr;
      wdata = req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (req_i.rd_en) rdata_q <= mem[req_i.rd_addr];
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clearing_q;

endmodule

FILE: sv/lpk_key_store.sv
module lpk_key_store (
  input  logic               clk_i,
  input  lpk_pkg::key_req_t  req_i,
  input  lpk_pkg::key_t      probe_key_i,
  output logic               match_o
);
  import lpk_pkg::*;

  key_t mem [MaxEntries];
  key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) mem[req_i.wr_addr] <= req_i.wr_key;
    if (req_i.rd_en) rdata_q <= mem[req_i.rd_addr];
  end

  assign match_o = (rdata_q == probe_key_i);

endmodule

FILE: sv/lpk_ctrl.sv
module lpk_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lpk_req_if.sink                     req_i,
  lpk_rsp_if.source                   rsp_o,
  input  logic                        slot_ready_i,
  input  logic [lpk_pkg::EntryW-1:0]  slot_rdata_i,
  output lpk_pkg::slot_req_t          slot_req_o,
  input  logic                        key_match_i,
  output lpk_pkg::key_req_t           key_req_o,
  output lpk_pkg::key_t               probe_key_o
);
  import lpk_pkg::*;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  key_t              key_q, key_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [EntryW-1:0] val_q, val_d;
  logic              found_q, found_d;
  logic [EntryW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [EntryW-1:0] out_index_q, out_index_d;

  logic accept;
  logic out_free;
  logic finish;
  logic do_insert;
  logic slot_empty;

  assign accept     = req_i.valid && req_i.ready;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign finish     = (state_q == S_FINISH) && out_free;
  assign slot_empty = (slot_rdata_i == '0);
  assign do_insert  = (op_q == OP_INSERT) && !found_q &&
                      (count_q != EntryW'(MaxEntries));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (accept) state_d = S_SLOT_CHK;
      S_SLOT_CHK: state_d = slot_empty ? S_FINISH : S_KEY_CHK;
      S_KEY_CHK:  state_d = key_match_i ? S_FINISH : S_SLOT_CHK;
      S_FINISH:   if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs: handshake and memory ports
  always_comb begin
    req_i.ready = 1'b0;
    slot_req_o  = '0;
    key_req_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready        = slot_ready_i;
        slot_req_o.rd_en   = accept;
        slot_req_o.rd_addr = req_i.key_hi[SlotW-1:0];
      end
      S_SLOT_CHK: begin
        key_req_o.rd_en   = !slot_empty;
        key_req_o.rd_addr = slot_rdata_i - EntryW'(1);
      end
      S_KEY_CHK: begin
        slot_req_o.rd_en   = !key_match_i;
        slot_req_o.rd_addr = slot_q + SlotW'(1);
      end
      S_FINISH: begin
        slot_req_o.wr_en   = finish && do_insert;
        slot_req_o.wr_addr = slot_q;
        slot_req_o.wr_data = count_q + EntryW'(1);
        key_req_o.wr_en    = finish && do_insert;
        key_req_o.wr_addr  = count_q;
        key_req_o.wr_key   = key_q;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    slot_d       = slot_q;
    val_d        = val_q;
    found_d      = found_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;

    if (accept) begin
      op_d    = req_i.opcode;
      key_d   = '{hi: req_i.key_hi, mid: req_i.key_mid, lo: req_i.key_lo};
      slot_d  = req_i.key_hi[SlotW-1:0];
      found_d = 1'b0;
    end

    if (state_q == S_SLOT_CHK) val_d = slot_rdata_i;

    if (state_q == S_KEY_CHK) begin
      if (key_match_i) found_d = 1'b1;
      else             slot_d  = slot_q + SlotW'(1);
    end

    if (finish) begin
      out_valid_d = 1'b1;
      out_index_d = '0;
      if (op_q == OP_FIND) begin
        if (found_q) begin
          out_status_d = ST_OK;
          out_index_d  = val_q - EntryW'(1);
        end else begin
          out_status_d = ST_NOT_FOUND;
        end
      end else if (found_q) begin
        out_status_d = ST_DUPLICATE;
      end else if (!do_insert) begin
        out_status_d = ST_FULL;
      end else begin
        out_status_d = ST_OK;
        out_index_d  = count_q;
        count_d      = count_q + EntryW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    slot_q       <= slot_d;
    val_q        <= val_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_index = out_index_q;
  assign probe_key_o       = key_q;

endmodule

FILE: sv/linear_probe_key_index_table_top.sv
// Hash index for 160-bit keys: a find returns the entry number of a stored key, an insert
// appends the key as the next entry and links it into a 1024-slot table probed linearly
// from key bits 9..0. After reset the slot table is swept clear, during which no beat is
// accepted. The next item is not accepted until this one has finished its probe, which
// stops when it meets the key or an empty slot; each occupied slot that it meets costs a
// slot-table read followed by a key-store read, both memories having registered reads.
// A result waits in an output register, so the next beat is taken while it is still
// pending, but that item cannot finish until the pending result is taken.
// Inserts are refused with a full status once 767 entries are stored.
module linear_probe_key_index_table_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpk_req_if.sink    req_i,
  lpk_rsp_if.source  rsp_o
);
  import lpk_pkg::*;

  slot_req_t         slot_req;
  logic [EntryW-1:0] slot_rdata;
  logic              slot_ready;
  key_req_t          key_req;
  key_t              probe_key;
  logic              key_match;

  lpk_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (slot_req),
    .rdata_o (slot_rdata),
    .ready_o (slot_ready)
  );

  lpk_key_store u_key_store (
    .clk_i       (clk_i),
    .req_i       (key_req),
    .probe_key_i (probe_key),
    .match_o     (key_match)
  );

  lpk_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .slot_ready_i (slot_ready),
    .slot_rdata_i (slot_rdata),
    .slot_req_o   (slot_req),
    .key_match_i  (key_match),
    .key_req_o    (key_req),
    .probe_key_o  (probe_key)
  );

endmodule
